FILE: rtl/vectored_interrupt_controller_64_defines.svh
// Assertion helpers used by the controller RTL.
`ifndef VECTORED_INTERRUPT_CONTROLLER_64_DEFINES_SVH
`define VECTORED_INTERRUPT_CONTROLLER_64_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define VIC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("vic64 check failed");

// Next-cycle implication, checked out of reset.
`define VIC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("vic64 check failed");

`endif

FILE: rtl/vic64_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vic64_pkg;

  localparam int NumLines  = 64;
  localparam int LineWordW = 64;
  localparam int NumW      = 7;
  localparam int PrioGrpN  = 8;
  localparam int PrioGrpW  = 8;

  localparam logic [LineWordW-1:0] LineMask = {LineWordW{1'b1}} >> (LineWordW - NumLines);
  localparam logic [NumW-1:0]      NumLinesC = NumW'(NumLines);
  localparam logic [NumW-1:0]      NoneLatched = {NumW{1'b1}};

  typedef enum logic [1:0] {
    ReqRead  = 2'd0,
    ReqWrite = 2'd1,
    ReqLine  = 2'd2
  } req_type_e;

  // Register word indexes
  localparam logic [9:0] RegFsel0    = 10'd0;
  localparam logic [9:0] RegFsel1    = 10'd1;
  localparam logic [9:0] RegEn0      = 10'd2;
  localparam logic [9:0] RegEn1      = 10'd3;
  localparam logic [9:0] RegEnClr0   = 10'd4;
  localparam logic [9:0] RegEnClr1   = 10'd5;
  localparam logic [9:0] RegSoft0    = 10'd6;
  localparam logic [9:0] RegSoft1    = 10'd7;
  localparam logic [9:0] RegSoftClr0 = 10'd8;
  localparam logic [9:0] RegSoftClr1 = 10'd9;
  localparam logic [9:0] RegMask     = 10'd10;
  localparam logic [9:0] RegRaw0     = 10'd12;
  localparam logic [9:0] RegRaw1     = 10'd13;
  localparam logic [9:0] RegPendN0   = 10'd14;
  localparam logic [9:0] RegPendN1   = 10'd15;
  localparam logic [9:0] RegPendF0   = 10'd16;
  localparam logic [9:0] RegPendF1   = 10'd17;
  localparam logic [9:0] RegActN0    = 10'd18;
  localparam logic [9:0] RegActN1    = 10'd19;
  localparam logic [9:0] RegActF0    = 10'd20;
  localparam logic [9:0] RegActF1    = 10'd21;
  localparam logic [9:0] RegActNB0   = 10'd22;
  localparam logic [9:0] RegActNB1   = 10'd23;
  localparam logic [9:0] RegActFB0   = 10'd24;
  localparam logic [9:0] RegActFB1   = 10'd25;
  localparam logic [9:0] RegBaseN    = 10'd28;
  localparam logic [9:0] RegBaseF    = 10'd29;
  localparam logic [9:0] RegTopN     = 10'd30;
  localparam logic [9:0] RegTopF     = 10'd31;
  localparam logic [9:0] RegVecN     = 10'd32;
  localparam logic [9:0] RegVecF     = 10'd33;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [9:0]  reg_index;
    logic [31:0] write_data;
    logic [5:0]  line_number;
    logic        line_level;
  } vic64_req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        fiq_out;
    logic        bad_offset;
  } vic64_rsp_t;

  function automatic logic [31:0] get_half(input logic [LineWordW-1:0] w, input logic hi);
    return hi ? w[63:32] : w[31:0];
  endfunction

  function automatic logic [LineWordW-1:0] put_half(input logic [LineWordW-1:0] w,
                                                    input logic hi, input logic [31:0] v);
    logic [LineWordW-1:0] r;
    r = w;
    if (hi) begin
      r[63:32] = v;
    end else begin
      r[31:0] = v;
    end
    return r & LineMask;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/vic64_prio.sv
`timescale 1ns / 1ps
`default_nettype none
// Highest set bit of a 64-bit word, all ones when the word is zero.
// Two levels: highest bit inside each byte, then highest non-empty byte.
module vic64_prio (
  input  logic [vic64_pkg::LineWordW-1:0] word_i,
  output logic [vic64_pkg::NumW-1:0]      num_o
);

  logic [vic64_pkg::PrioGrpN-1:0] grp_any;
  logic [2:0]                     grp_idx [vic64_pkg::PrioGrpN];
  logic [2:0]                     grp_sel;

  always_comb begin
    for (int g = 0; g < vic64_pkg::PrioGrpN; g++) begin
      grp_any[g] = |word_i[g*vic64_pkg::PrioGrpW +: vic64_pkg::PrioGrpW];
      grp_idx[g] = '0;
      for (int b = 0; b < vic64_pkg::PrioGrpW; b++) begin
        if (word_i[g*vic64_pkg::PrioGrpW + b]) begin
          grp_idx[g] = 3'(b);
        end
      end
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = 0; g < vic64_pkg::PrioGrpN; g++) begin
      if (grp_any[g]) begin
        grp_sel = 3'(g);
      end
    end
  end

  assign num_o = (|grp_any) ? {1'b0, grp_sel, grp_idx[grp_sel]} : vic64_pkg::NoneLatched;

endmodule
`default_nettype wire

FILE: rtl/vectored_interrupt_controller_64.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | Valid       | Stall        | Payload
// request  | in_valid_i  | in_stall_o   | in_req_i  (vic64_req_t)
// response | out_valid_o | out_stall_i  | out_rsp_o (vic64_rsp_t)
//
// One request per cycle while the response is not stalled; an accepted request
// passes the input register, then the decode/update logic into the response register.
// The longest path is the 64-bit priority encode feeding the read mux.
// Reset clears all line words, the mask, the table bases and sets both latched
// numbers to none. A stalled response holds the request register; the request
// side stalls only while both registers are full and the response is stalled.
module vectored_interrupt_controller_64 (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  vic64_pkg::vic64_req_t  in_req_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output vic64_pkg::vic64_rsp_t  out_rsp_o
);

  logic                   in_valid_q;
  vic64_pkg::vic64_req_t  in_q;
  logic                   out_valid_q;
  vic64_pkg::vic64_rsp_t  out_q, rsp_d;
  logic                   advance, in_accept;

  logic [63:0] fsel_q, fsel_d, en_q, en_d, soft_q, soft_d, raw_q, raw_d;
  logic [1:0]  mask_q, mask_d;
  logic [31:0] base_n_q, base_n_d, base_f_q, base_f_d;
  logic [6:0]  lat_n_q, lat_n_d, lat_f_q, lat_f_d;

  logic [63:0] pn_q, pf_q, pn_d, pf_d;
  logic [6:0]  top_n, top_f;
  logic        hi, idx_ok, is_access;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign pn_q = (soft_q | raw_q) & ~fsel_q & en_q;
  assign pf_q = (soft_q | raw_q) & fsel_q & en_q;

  vic64_prio u_prio_n (.word_i(pn_q), .num_o(top_n));
  vic64_prio u_prio_f (.word_i(pf_q), .num_o(top_f));

  assign hi = in_q.reg_index[0];

  always_comb begin
    unique case (in_q.reg_index)
      vic64_pkg::RegFsel0, vic64_pkg::RegFsel1, vic64_pkg::RegEn0, vic64_pkg::RegEn1,
      vic64_pkg::RegEnClr0, vic64_pkg::RegEnClr1, vic64_pkg::RegSoft0, vic64_pkg::RegSoft1,
      vic64_pkg::RegSoftClr0, vic64_pkg::RegSoftClr1, vic64_pkg::RegMask,
      vic64_pkg::RegRaw0, vic64_pkg::RegRaw1, vic64_pkg::RegPendN0, vic64_pkg::RegPendN1,
      vic64_pkg::RegPendF0, vic64_pkg::RegPendF1, vic64_pkg::RegActN0, vic64_pkg::RegActN1,
      vic64_pkg::RegActF0, vic64_pkg::RegActF1, vic64_pkg::RegActNB0, vic64_pkg::RegActNB1,
      vic64_pkg::RegActFB0, vic64_pkg::RegActFB1, vic64_pkg::RegBaseN, vic64_pkg::RegBaseF,
      vic64_pkg::RegTopN, vic64_pkg::RegTopF, vic64_pkg::RegVecN,
      vic64_pkg::RegVecF: idx_ok = 1'b1;
      default:            idx_ok = 1'b0;
    endcase
  end

  assign is_access = (in_q.req_type == vic64_pkg::ReqRead) ||
                     (in_q.req_type == vic64_pkg::ReqWrite);

  always_comb begin
    rsp_d    = '0;
    fsel_d   = fsel_q;
    en_d     = en_q;
    soft_d   = soft_q;
    raw_d    = raw_q;
    mask_d   = mask_q;
    base_n_d = base_n_q;
    base_f_d = base_f_q;
    lat_n_d  = lat_n_q;
    lat_f_d  = lat_f_q;

    unique case (vic64_pkg::req_type_e'(in_q.req_type))
      vic64_pkg::ReqRead: begin
        unique case (in_q.reg_index)
          vic64_pkg::RegFsel0, vic64_pkg::RegFsel1:
            rsp_d.read_data = vic64_pkg::get_half(fsel_q, hi);
          vic64_pkg::RegEn0, vic64_pkg::RegEn1:
            rsp_d.read_data = vic64_pkg::get_half(en_q, hi);
          vic64_pkg::RegSoft0, vic64_pkg::RegSoft1:
            rsp_d.read_data = vic64_pkg::get_half(soft_q, hi);
          vic64_pkg::RegMask:
            rsp_d.read_data = {30'd0, mask_q};
          vic64_pkg::RegRaw0, vic64_pkg::RegRaw1:
            rsp_d.read_data = vic64_pkg::get_half(raw_q, hi);
          vic64_pkg::RegPendN0, vic64_pkg::RegPendN1:
            rsp_d.read_data = vic64_pkg::get_half((soft_q | raw_q) & ~fsel_q, hi);
          vic64_pkg::RegPendF0, vic64_pkg::RegPendF1:
            rsp_d.read_data = vic64_pkg::get_half((soft_q | raw_q) & fsel_q, hi);
          vic64_pkg::RegActN0, vic64_pkg::RegActN1, vic64_pkg::RegActNB0,
          vic64_pkg::RegActNB1:
            rsp_d.read_data = vic64_pkg::get_half(pn_q, hi);
          vic64_pkg::RegActF0, vic64_pkg::RegActF1, vic64_pkg::RegActFB0,
          vic64_pkg::RegActFB1:
            rsp_d.read_data = vic64_pkg::get_half(pf_q, hi);
          vic64_pkg::RegBaseN: rsp_d.read_data = base_n_q;
          vic64_pkg::RegBaseF: rsp_d.read_data = base_f_q;
          vic64_pkg::RegTopN: begin
            lat_n_d = top_n;
            rsp_d.read_data = (top_n == vic64_pkg::NoneLatched) ? '1 : {25'd0, top_n};
          end
          vic64_pkg::RegTopF: begin
            lat_f_d = top_f;
            rsp_d.read_data = (top_f == vic64_pkg::NoneLatched) ? '1 : {25'd0, top_f};
          end
          vic64_pkg::RegVecN:
            rsp_d.read_data = (lat_n_q == vic64_pkg::NoneLatched) ? '0 :
                              base_n_q + {23'd0, lat_n_q, 2'b00};
          vic64_pkg::RegVecF:
            rsp_d.read_data = (lat_f_q == vic64_pkg::NoneLatched) ? '0 :
                              base_f_q + {23'd0, lat_f_q, 2'b00};
          default: rsp_d.read_data = '0;
        endcase
      end
      vic64_pkg::ReqWrite: begin
        unique case (in_q.reg_index)
          vic64_pkg::RegFsel0, vic64_pkg::RegFsel1:
            fsel_d = vic64_pkg::put_half(fsel_q, hi, in_q.write_data);
          vic64_pkg::RegEn0, vic64_pkg::RegEn1:
            en_d = vic64_pkg::put_half(en_q, hi, in_q.write_data);
          vic64_pkg::RegEnClr0, vic64_pkg::RegEnClr1:
            en_d = vic64_pkg::put_half(en_q, hi,
                     vic64_pkg::get_half(en_q, hi) & ~in_q.write_data);
          vic64_pkg::RegSoft0, vic64_pkg::RegSoft1:
            soft_d = vic64_pkg::put_half(soft_q, hi, in_q.write_data);
          vic64_pkg::RegSoftClr0, vic64_pkg::RegSoftClr1:
            soft_d = vic64_pkg::put_half(soft_q, hi,
                       vic64_pkg::get_half(soft_q, hi) & ~in_q.write_data);
          vic64_pkg::RegMask:  mask_d   = in_q.write_data[1:0];
          vic64_pkg::RegBaseN: base_n_d = in_q.write_data;
          vic64_pkg::RegBaseF: base_f_d = in_q.write_data;
          default: ;
        endcase
      end
      vic64_pkg::ReqLine: begin
        // drop changes on lines past the configured count
        if ({1'b0, in_q.line_number} < vic64_pkg::NumLinesC) begin
          soft_d[in_q.line_number] = in_q.line_level;
          raw_d[in_q.line_number]  = in_q.line_level;
        end
      end
      default: ;
    endcase

    rsp_d.bad_offset = is_access && !idx_ok;
    rsp_d.irq_out    = (|pn_d) && !mask_d[0];
    rsp_d.fiq_out    = (|pf_d) && !mask_d[1];
  end

  assign pn_d = (soft_d | raw_d) & ~fsel_d & en_d;
  assign pf_d = (soft_d | raw_d) & fsel_d & en_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      fsel_q      <= '0;
      en_q        <= '0;
      soft_q      <= '0;
      raw_q       <= '0;
      mask_q      <= '0;
      base_n_q    <= '0;
      base_f_q    <= '0;
      lat_n_q     <= vic64_pkg::NoneLatched;
      lat_f_q     <= vic64_pkg::NoneLatched;
    end else begin
      in_valid_q  <= in_accept || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
      if (advance) begin
        fsel_q   <= fsel_d;
        en_q     <= en_d;
        soft_q   <= soft_d;
        raw_q    <= raw_d;
        mask_q   <= mask_d;
        base_n_q <= base_n_d;
        base_f_q <= base_f_d;
        lat_n_q  <= lat_n_d;
        lat_f_q  <= lat_f_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_req_i;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

`include "vectored_interrupt_controller_64_defines.svh"

  `VIC_ASSERT_NOW(a_stall_only_when_blocked, in_stall_o, out_valid_o && out_stall_i)
  `VIC_ASSERT_NEXT(a_advance_fills_output, advance, out_valid_o)
  `VIC_ASSERT_NEXT(a_irq_tracks_state, advance,
                   out_rsp_o.irq_out == ((|pn_q) && !mask_q[0]))
  `VIC_ASSERT_NEXT(a_fiq_tracks_state, advance,
                   out_rsp_o.fiq_out == ((|pf_q) && !mask_q[1]))
  `VIC_ASSERT_NEXT(a_bad_offset_no_change, advance && rsp_d.bad_offset,
                   $stable(fsel_q) && $stable(en_q) && $stable(soft_q) && $stable(mask_q))

endmodule
`default_nettype wire
